// ===== hw/rtl/gctp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gctp_pkg
// Shared types and constants for the greedy cost-weighted tree pick block.
// ----------------------------------------------------------------------------
package gctp_pkg;

    localparam int MAX_TREES_DEF = 1024;
    localparam int FRAC_BITS_DEF = 8;

    localparam int COORD_W   = 24;
    localparam int SCORE_W   = 40;
    localparam int IDX_OUT_W = 10;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam int FLOOR_UNITS = 1000000;

    // distance datapath widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = (SUM_W + 1) / 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TREE_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANAGE_COST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_COST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DIST   = 2'd3;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_PERSON = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      is_protected;
    } in_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]      tree_index;
        logic signed [SCORE_W-1:0] best_score;
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic                      felled;
    } out_item_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] tree_value;
        logic signed [CFG_W-1:0] manage_cost;
        logic signed [CFG_W-1:0] travel_cost;
        logic signed [CFG_W-1:0] step_distance;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic load_we;
        logic scan_issue;
        logic fin_read;
        logic fin_write;
        logic no_trees;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/gctp_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gctp_isqrt
// Pipelined integer square root, two radicand bits resolved per stage.
// ----------------------------------------------------------------------------
module gctp_isqrt
    import gctp_pkg::*;
#(
    parameter int TAG_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [SUM_W-1:0] in_rad,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [TAG_W-1:0] out_tag,
    output logic             busy
);

    localparam int NP_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic [REM_W-1:0]  rem_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [0:ROOT_W-1];
    logic [NP_W-1:0]   rad_reg   [0:ROOT_W-1];
    logic [TAG_W-1:0]  tag_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0] vld_reg;

    logic [REM_W-1:0]  rem_next  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_next [0:ROOT_W-1];
    logic [NP_W-1:0]   rad_next  [0:ROOT_W-1];

    always_comb begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [NP_W-1:0]   rad_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = NP_W'(in_rad);
            end else begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rad_in  = rad_reg[k-1];
            end
            cur   = {rem_in, rad_in[NP_W-1 -: 2]};
            trial = (REM_W+2)'({root_in, 2'b01});
            if (cur >= trial) begin
                rem_next[k]  = REM_W'(cur - trial);
                root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = cur[REM_W-1:0];
                root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[k] = {rad_in[NP_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            rad_reg[k]  <= rad_next[k];
            tag_reg[k]  <= (k == 0) ? in_tag : tag_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];
    assign busy      = |vld_reg;

endmodule

// ===== hw/rtl/gctp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gctp_datapath
// Tree stores, distance and score pipeline, best tracking and person step.
// ----------------------------------------------------------------------------
module gctp_datapath
    import gctp_pkg::*;
#(
    parameter int MAX_TREES = MAX_TREES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int IDX_W     = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    input  logic [IDX_W-1:0] addr,
    input  in_item_t         s_item,
    input  cfg_t             cfg,
    output logic             pipe_busy,
    output out_item_t        result
);

    localparam int PROD_W = ROOT_W + 1 + CFG_W;
    localparam int SC_W   = PROD_W + 2;
    localparam logic signed [SCORE_W-1:0] FLOOR_SCORE =
        -($signed(SCORE_W'(FLOOR_UNITS)) <<< FRAC_BITS);

    logic signed [COORD_W-1:0] x_mem [0:MAX_TREES-1];
    logic signed [COORD_W-1:0] y_mem [0:MAX_TREES-1];
    logic                      p_mem [0:MAX_TREES-1];
    logic                      f_mem [0:MAX_TREES-1];

    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg;
    logic                      p1_reg, f1_reg;
    logic [IDX_W-1:0]          id1_reg;
    logic                      v1_reg;

    logic signed [DIFF_W-1:0]  dx2_reg, dy2_reg;
    logic                      p2_reg, v2_reg;
    logic [IDX_W-1:0]          id2_reg;

    logic [SQ_W-1:0]           sqx3_reg, sqy3_reg;
    logic                      p3_reg, v3_reg;
    logic [IDX_W-1:0]          id3_reg;

    logic signed [SQ_W-1:0]    sqx_full, sqy_full;

    logic                      isq_valid, isq_busy;
    logic [ROOT_W-1:0]         isq_root;
    logic [IDX_W:0]            isq_tag;

    logic signed [PROD_W-1:0]  prod5_reg;
    logic                      p5_reg, v5_reg;
    logic [IDX_W-1:0]          id5_reg;

    logic signed [SC_W-1:0]    sc_raw;
    logic signed [SCORE_W-1:0] sc_sat;
    logic signed [SCORE_W-1:0] sc6_reg;
    logic                      v6_reg;
    logic [IDX_W-1:0]          id6_reg;

    logic signed [SCORE_W-1:0] best_reg;
    logic [IDX_W-1:0]          best_id_reg;

    logic [IDX_W-1:0]          rd_addr;
    logic                      best_pos;
    logic signed [COORD_W-1:0] tx, ty;

    // Tree stores: one write and one registered read per cycle.
    assign rd_addr = cmd.fin_read ? best_id_reg : addr;

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            x_mem[addr] <= s_item.pos_x;
            y_mem[addr] <= s_item.pos_y;
            p_mem[addr] <= s_item.is_protected;
        end
        if (cmd.scan_issue || cmd.fin_read) begin
            x1_reg <= x_mem[rd_addr];
            y1_reg <= y_mem[rd_addr];
            p1_reg <= p_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            f_mem[addr] <= 1'b0;
        end else if (cmd.fin_write && best_pos) begin
            f_mem[best_id_reg] <= 1'b1;
        end
        if (cmd.scan_issue) begin
            f1_reg <= f_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg <= s_item.pos_x;
            py_reg <= s_item.pos_y;
        end
        id1_reg  <= addr;
        dx2_reg  <= DIFF_W'(px_reg) - DIFF_W'(x1_reg);
        dy2_reg  <= DIFF_W'(py_reg) - DIFF_W'(y1_reg);
        p2_reg   <= p1_reg;
        id2_reg  <= id1_reg;
        sqx3_reg <= sqx_full;
        sqy3_reg <= sqy_full;
        p3_reg   <= p2_reg;
        id3_reg  <= id2_reg;
        prod5_reg <= $signed({1'b0, isq_root}) * cfg.travel_cost;
        p5_reg   <= isq_tag[IDX_W];
        id5_reg  <= isq_tag[IDX_W-1:0];
        sc6_reg  <= sc_sat;
        id6_reg  <= id5_reg;
    end

    assign sqx_full = dx2_reg * dx2_reg;
    assign sqy_full = dy2_reg * dy2_reg;

    gctp_isqrt #(
        .TAG_W (IDX_W + 1)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3_reg),
        .in_rad    (SUM_W'(sqx3_reg) + SUM_W'(sqy3_reg)),
        .in_tag    ({p3_reg, id3_reg}),
        .out_valid (isq_valid),
        .out_root  (isq_root),
        .out_tag   (isq_tag),
        .busy      (isq_busy)
    );

    // Score, then saturate to the result width before the compare.
    always_comb begin
        sc_raw = SC_W'(cfg.tree_value) - SC_W'(prod5_reg >>> FRAC_BITS)
               - (p5_reg ? SC_W'(cfg.manage_cost) : SC_W'(0));
        if (sc_raw[SC_W-1:SCORE_W-1] == '0 || sc_raw[SC_W-1:SCORE_W-1] == '1) begin
            sc_sat = sc_raw[SCORE_W-1:0];
        end else if (sc_raw[SC_W-1]) begin
            sc_sat = {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            sc_sat = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg && !f1_reg;
            v3_reg <= v2_reg;
            v5_reg <= isq_valid;
            v6_reg <= v5_reg;
        end
    end

    // Strictly greater only, so the first of equal scores is kept.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            best_reg    <= FLOOR_SCORE;
            best_id_reg <= '0;
        end else if (v6_reg && (sc6_reg > best_reg)) begin
            best_reg    <= sc6_reg;
            best_id_reg <= id6_reg;
        end
    end

    assign pipe_busy = v1_reg || v2_reg || v3_reg || isq_busy || v5_reg || v6_reg;
    assign best_pos  = (best_reg > 0);

    assign tx = cmd.no_trees ? '0 : x1_reg;
    assign ty = cmd.no_trees ? '0 : y1_reg;

    function automatic logic signed [COORD_W-1:0] step_axis(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] t,
        input logic signed [CFG_W-1:0]   step
    );
        logic signed [COORD_W+1:0] r;
        r = (p < t) ? (COORD_W+2)'(p) + (COORD_W+2)'(step)
                    : (COORD_W+2)'(p) - (COORD_W+2)'(step);
        if (r[COORD_W+1:COORD_W-1] == '0 || r[COORD_W+1:COORD_W-1] == '1) begin
            return r[COORD_W-1:0];
        end else if (r[COORD_W+1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    always_comb begin
        result.tree_index = IDX_OUT_W'(best_id_reg);
        result.best_score = best_reg;
        result.new_x      = step_axis(px_reg, tx, cfg.step_distance);
        result.new_y      = step_axis(py_reg, ty, cfg.step_distance);
        result.felled     = best_pos;
    end

endmodule

// ===== hw/rtl/gctp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gctp_ctrl
// Sequencer: tree loads, scan issue, drain, winner fetch and result handoff.
// ----------------------------------------------------------------------------
module gctp_ctrl
    import gctp_pkg::*;
#(
    parameter int MAX_TREES = MAX_TREES_DEF,
    parameter int IDX_W     = 10,
    parameter int CNT_W     = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_mode,
    output logic             s_ready,
    input  status_t          sts,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] addr
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             accept, full;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(MAX_TREES));

    always_comb begin
        cmd.capture    = accept && (s_mode == MODE_PERSON);
        cmd.load_we    = accept && (s_mode == MODE_LOAD) && !full;
        cmd.scan_issue = (state_reg == ST_SCAN);
        cmd.fin_read   = (state_reg == ST_FETCH);
        cmd.fin_write  = (state_reg == ST_FIN) && sts.out_free;
        cmd.no_trees   = (count_reg == '0);
        addr = (state_reg == ST_IDLE) ? count_reg[IDX_W-1:0] : scan_reg;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load_we) begin
                    count_next = count_reg + 1'b1;
                end
                if (cmd.capture) begin
                    scan_next  = '0;
                    state_next = cmd.no_trees ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (CNT_W'(scan_reg) == count_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TREES))
        else $error("tree count beyond capacity");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_issue |-> (CNT_W'(scan_reg) < count_reg))
        else $error("scan address beyond stored trees");

    a_fin_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_read |-> !sts.pipe_busy)
        else $error("winner fetched while scores still in flight");

    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_write |-> sts.out_free)
        else $error("result written over an untaken result");

endmodule

// ===== hw/rtl/greedy_cost_weighted_tree_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_cost_weighted_tree_pick
// Stores trees and picks, per person, the best-scoring unfelled tree.
//
//   channel  ports                     payload     direction
//   input    s_valid/s_ready/s_data    in_item_t   in
//   result   m_valid/m_ready/m_data    out_item_t  out
//   config   cfg_we/cfg_index/cfg_data cfg_t reg   in
//
// One person is scanned at one tree per cycle from the store read port, then
// the score pipeline drains (square root stages dominate), then a winner
// fetch and handoff follow; a person with no stored trees skips the scan.
// Reset (aresetn low, synchronous) clears control state, tree count, valid bits and config; felled flags clear on load.
// A pending result holds in the output register; a new person waits for it
// to transfer only at its final handoff cycle.
// ----------------------------------------------------------------------------
module greedy_cost_weighted_tree_pick
    import gctp_pkg::*;
#(
    parameter int MAX_TREES = MAX_TREES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int CNT_W = $clog2(MAX_TREES + 1);

    cfg_t       cfg_reg;
    cmd_t       cmd;
    status_t    sts;
    logic [IDX_W-1:0] addr;
    logic       pipe_busy;
    out_item_t  result;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TREE_VALUE:  cfg_reg.tree_value    <= cfg_data;
                CFG_MANAGE_COST: cfg_reg.manage_cost   <= cfg_data;
                CFG_TRAVEL_COST: cfg_reg.travel_cost   <= cfg_data;
                CFG_STEP_DIST:   cfg_reg.step_distance <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign sts.pipe_busy = pipe_busy;
    assign sts.out_free  = !m_valid_reg || m_ready;

    gctp_ctrl #(
        .MAX_TREES (MAX_TREES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .addr    (addr)
    );

    gctp_datapath #(
        .MAX_TREES (MAX_TREES),
        .FRAC_BITS (FRAC_BITS),
        .IDX_W     (IDX_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .addr      (addr),
        .s_item    (s_data),
        .cfg       (cfg_reg),
        .pipe_busy (pipe_busy),
        .result    (result)
    );

    // Output register: load on handoff, drop on transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.fin_write) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_write) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
